FILE: hw/rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types and constants of the bitmap header parser: status codes,
// header byte positions, valid header sizes and the result record.
// ----------------------------------------------------------------------------
package bhp_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_BAD_PLANES = 3'd3,
    ST_BAD_BPP    = 3'd4,
    ST_COMPRESSED = 3'd5
  } bhp_status_t;

  // Byte positions at which a decision is taken.
  localparam logic [5:0] POS_SIZE_LAST = 6'd17;
  localparam logic [5:0] POS_CORE_LAST = 6'd25;
  localparam logic [5:0] POS_INFO_LAST = 6'd53;

  // DIB header sizes.
  localparam logic [31:0] HS_CORE      = 32'd12;
  localparam logic [31:0] HS_CORE_OS2  = 32'd64;
  localparam logic [31:0] HS_INFO      = 32'd40;
  localparam logic [31:0] HS_INFO_V2   = 32'd52;
  localparam logic [31:0] HS_INFO_V3   = 32'd56;
  localparam logic [31:0] HS_INFO_V4   = 32'd108;
  localparam logic [31:0] HS_INFO_V5   = 32'd124;

  // Output tdata width: 323 payload bits rounded up to whole bytes.
  localparam int OUT_PAYLOAD_W = 323;
  localparam int OUT_TDATA_W   = 328;

  // One parse result.
  typedef struct packed {
    logic [31:0]        color_count;
    logic signed [31:0] vertical_ppm;
    logic signed [31:0] horizontal_ppm;
    logic [31:0]        image_size;
    logic [15:0]        pixel_bits;
    logic signed [31:0] img_height;
    logic signed [31:0] img_width;
    logic [31:0]        header_size;
    logic [31:0]        data_offset;
    logic [31:0]        file_bytes;
    logic [15:0]        sig_word;
    bhp_status_t        status;
  } bhp_result_t;

  // Byte request handed from the input register to the capture logic.
  typedef struct packed {
    logic       fire;
    logic [7:0] data_byte;
    logic       frame_end;
  } bhp_byte_req_t;

endpackage

FILE: hw/rtl/bhp_capture.sv
// ----------------------------------------------------------------------------
// bhp_capture
// Header field capture by byte position, layout selection and header
// checks. Produces at most one result per file.
// ----------------------------------------------------------------------------
module bhp_capture
  import bhp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  bhp_byte_req_t req,
  output logic          res_valid,
  output bhp_result_t   res
);

  localparam logic [5:0] B_SIG     = 6'd0;
  localparam logic [5:0] B_FSIZE   = 6'd2;
  localparam logic [5:0] B_OFFSET  = 6'd10;
  localparam logic [5:0] B_HSIZE   = 6'd14;
  localparam logic [5:0] B_C_WIDTH = 6'd18;
  localparam logic [5:0] B_C_HEIGHT = 6'd20;
  localparam logic [5:0] B_C_BPP   = 6'd24;
  localparam logic [5:0] B_I_WIDTH = 6'd18;
  localparam logic [5:0] B_I_HEIGHT = 6'd22;
  localparam logic [5:0] B_I_PLANES = 6'd26;
  localparam logic [5:0] B_I_BPP   = 6'd28;
  localparam logic [5:0] B_I_COMP  = 6'd30;
  localparam logic [5:0] B_I_ISIZE = 6'd34;
  localparam logic [5:0] B_I_HRES  = 6'd38;
  localparam logic [5:0] B_I_VRES  = 6'd42;
  localparam logic [5:0] B_I_COLORS = 6'd46;

  // Little-endian byte insertion into a 32-bit field.
  function automatic logic [31:0] put32(logic [31:0] acc, logic [5:0] p,
                                        logic [5:0] base, logic [5:0] len,
                                        logic [7:0] b);
    logic [5:0]  off;
    logic [31:0] r;
    off = p - base;
    r   = acc;
    if (p >= base && p < base + len) begin
      r[{off[1:0], 3'b000} +: 8] = b;
    end
    return r;
  endfunction

  // Little-endian byte insertion into a 16-bit field.
  function automatic logic [15:0] put16(logic [15:0] acc, logic [5:0] p,
                                        logic [5:0] base, logic [7:0] b);
    logic [5:0]  off;
    logic [15:0] r;
    off = p - base;
    r   = acc;
    if (p >= base && p < base + 6'd2) begin
      r[{off[0], 3'b000} +: 8] = b;
    end
    return r;
  endfunction

  logic [5:0]  pos_r, pos_nxt;
  logic        core_r, core_nxt;
  logic        given_r, given_nxt;
  logic [15:0] sig_r, sig_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] planes_r, planes_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [31:0] isize_r, isize_nxt;
  logic [31:0] hres_r, hres_nxt;
  logic [31:0] vres_r, vres_nxt;
  logic [31:0] colors_r, colors_nxt;

  // Captured values including the current byte, before a frame restart.
  logic [5:0]  cap_pos;
  logic        cap_core, cap_given;
  logic [15:0] cap_sig, cap_planes, cap_bpp;
  logic [31:0] cap_fsize, cap_offset, cap_hsize, cap_width, cap_height;
  logic [31:0] cap_comp, cap_isize, cap_hres, cap_vres, cap_colors;
  bhp_status_t st;
  logic        emit;
  logic        size_core, size_info, bpp_good;

  // Capture, decide and restart.
  always_comb begin
    cap_pos    = pos_r;
    cap_core   = core_r;
    cap_given  = given_r;
    cap_sig    = sig_r;
    cap_fsize  = fsize_r;
    cap_offset = offset_r;
    cap_hsize  = hsize_r;
    cap_width  = width_r;
    cap_height = height_r;
    cap_planes = planes_r;
    cap_bpp    = bpp_r;
    cap_comp   = comp_r;
    cap_isize  = isize_r;
    cap_hres   = hres_r;
    cap_vres   = vres_r;
    cap_colors = colors_r;
    st         = ST_OK;
    emit       = 1'b0;
    size_core  = 1'b0;
    size_info  = 1'b0;
    bpp_good   = 1'b0;

    if (req.fire && !given_r) begin
      cap_sig    = put16(sig_r, pos_r, B_SIG, req.data_byte);
      cap_fsize  = put32(fsize_r, pos_r, B_FSIZE, 6'd4, req.data_byte);
      cap_offset = put32(offset_r, pos_r, B_OFFSET, 6'd4, req.data_byte);
      cap_hsize  = put32(hsize_r, pos_r, B_HSIZE, 6'd4, req.data_byte);

      size_core = (cap_hsize == HS_CORE) || (cap_hsize == HS_CORE_OS2);
      size_info = (cap_hsize == HS_INFO) || (cap_hsize == HS_INFO_V2) ||
                  (cap_hsize == HS_INFO_V3) || (cap_hsize == HS_INFO_V4) ||
                  (cap_hsize == HS_INFO_V5);

      if (pos_r == POS_SIZE_LAST) begin
        // Header size decides the layout or ends the file at once.
        if (size_core) begin
          cap_core = 1'b1;
        end else if (!size_info) begin
          st   = ST_BAD_SIZE;
          emit = 1'b1;
        end
      end else if (pos_r > POS_SIZE_LAST) begin
        if (core_r) begin
          // Core layout: 16-bit fields, no checks.
          cap_width[15:0]  = put16(width_r[15:0], pos_r, B_C_WIDTH, req.data_byte);
          cap_height[15:0] = put16(height_r[15:0], pos_r, B_C_HEIGHT, req.data_byte);
          cap_bpp          = put16(bpp_r, pos_r, B_C_BPP, req.data_byte);
          if (pos_r == POS_CORE_LAST) begin
            emit = 1'b1;
          end
        end else begin
          // Info layout: full fields, then planes, bpp and compression checks.
          cap_width  = put32(width_r, pos_r, B_I_WIDTH, 6'd4, req.data_byte);
          cap_height = put32(height_r, pos_r, B_I_HEIGHT, 6'd4, req.data_byte);
          cap_planes = put16(planes_r, pos_r, B_I_PLANES, req.data_byte);
          cap_bpp    = put16(bpp_r, pos_r, B_I_BPP, req.data_byte);
          cap_comp   = put32(comp_r, pos_r, B_I_COMP, 6'd4, req.data_byte);
          cap_isize  = put32(isize_r, pos_r, B_I_ISIZE, 6'd4, req.data_byte);
          cap_hres   = put32(hres_r, pos_r, B_I_HRES, 6'd4, req.data_byte);
          cap_vres   = put32(vres_r, pos_r, B_I_VRES, 6'd4, req.data_byte);
          cap_colors = put32(colors_r, pos_r, B_I_COLORS, 6'd4, req.data_byte);
          bpp_good = (cap_bpp == 16'd1) || (cap_bpp == 16'd4) || (cap_bpp == 16'd8) ||
                     (cap_bpp == 16'd16) || (cap_bpp == 16'd24) || (cap_bpp == 16'd32);
          if (pos_r == POS_INFO_LAST) begin
            emit = 1'b1;
            if (cap_planes != 16'd1) begin
              st = ST_BAD_PLANES;
            end else if (!bpp_good) begin
              st = ST_BAD_BPP;
            end else if (cap_comp != 32'd0) begin
              st = ST_COMPRESSED;
            end
          end
        end
      end

      if (emit) begin
        cap_given = 1'b1;
      end else begin
        cap_pos = pos_r + 6'd1;
        // Frame ended before the header was complete.
        if (req.frame_end) begin
          st        = ST_TRUNC;
          emit      = 1'b1;
          cap_given = 1'b1;
        end
      end
    end

    // Next state: the end of a frame restarts the parser.
    if (req.fire && req.frame_end) begin
      pos_nxt    = '0;
      core_nxt   = 1'b0;
      given_nxt  = 1'b0;
      sig_nxt    = '0;
      fsize_nxt  = '0;
      offset_nxt = '0;
      hsize_nxt  = '0;
      width_nxt  = '0;
      height_nxt = '0;
      planes_nxt = '0;
      bpp_nxt    = '0;
      comp_nxt   = '0;
      isize_nxt  = '0;
      hres_nxt   = '0;
      vres_nxt   = '0;
      colors_nxt = '0;
    end else begin
      pos_nxt    = cap_pos;
      core_nxt   = cap_core;
      given_nxt  = cap_given;
      sig_nxt    = cap_sig;
      fsize_nxt  = cap_fsize;
      offset_nxt = cap_offset;
      hsize_nxt  = cap_hsize;
      width_nxt  = cap_width;
      height_nxt = cap_height;
      planes_nxt = cap_planes;
      bpp_nxt    = cap_bpp;
      comp_nxt   = cap_comp;
      isize_nxt  = cap_isize;
      hres_nxt   = cap_hres;
      vres_nxt   = cap_vres;
      colors_nxt = cap_colors;
    end
  end

  // Result record from the values captured so far.
  always_comb begin
    res_valid          = emit;
    res.status         = st;
    res.sig_word       = cap_sig;
    res.file_bytes     = cap_fsize;
    res.data_offset    = cap_offset;
    res.header_size    = cap_hsize;
    res.img_width      = cap_width;
    res.img_height     = cap_height;
    res.pixel_bits     = cap_bpp;
    res.image_size     = cap_isize;
    res.horizontal_ppm = cap_hres;
    res.vertical_ppm   = cap_vres;
    res.color_count    = cap_colors;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      core_r   <= 1'b0;
      given_r  <= 1'b0;
      sig_r    <= '0;
      fsize_r  <= '0;
      offset_r <= '0;
      hsize_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      planes_r <= '0;
      bpp_r    <= '0;
      comp_r   <= '0;
      isize_r  <= '0;
      hres_r   <= '0;
      vres_r   <= '0;
      colors_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      core_r   <= core_nxt;
      given_r  <= given_nxt;
      sig_r    <= sig_nxt;
      fsize_r  <= fsize_nxt;
      offset_r <= offset_nxt;
      hsize_r  <= hsize_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      planes_r <= planes_nxt;
      bpp_r    <= bpp_nxt;
      comp_r   <= comp_nxt;
      isize_r  <= isize_nxt;
      hres_r   <= hres_nxt;
      vres_r   <= vres_nxt;
      colors_r <= colors_nxt;
    end
  end

  // The position never runs past the last info header byte.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_INFO_LAST)
    else $error("byte position beyond header end");

  // Once a file has its result, its remaining bytes give none.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && given_r) |-> !res_valid)
    else $error("second result for one file");

  // The core layout is only chosen once the header size is complete.
  a_core_pos: assert property (@(posedge clk) disable iff (!rst_n)
    core_r |-> (pos_r > POS_SIZE_LAST))
    else $error("core layout flag set before header size byte");

  // A bad header size is reported on the last header size byte.
  a_bad_size_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_BAD_SIZE) |-> (pos_r == POS_SIZE_LAST))
    else $error("bad size result at wrong byte");

  // The end of a frame restarts the parser at byte zero.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && req.frame_end) |=> (pos_r == '0 && !given_r && !core_r))
    else $error("parser did not restart after frame end");

endmodule

FILE: hw/rtl/bhp_out_stage.sv
// ----------------------------------------------------------------------------
// bhp_out_stage
// Result register of the parser. Holds one result until the receiver takes
// it and tells the upstream stage when it may advance.
// ----------------------------------------------------------------------------
module bhp_out_stage
  import bhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bhp_result_t res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output bhp_result_t out_res
);

  logic        valid_r, valid_nxt;
  bhp_result_t res_r;

  // The stage can take a new result when empty or when its result leaves.
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register; no reset needed.
  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: hw/rtl/bmp_header_parser_top.sv
// ----------------------------------------------------------------------------
// bmp_header_parser_top
// Bitmap file header and DIB header parser, one file byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one file byte per request in in_tdata; in_tlast
//   marks the last byte of a file. The parser captures the file header and
//   the DIB header by byte position and sends exactly one result request per
//   file on the output stream: the header fields and a status (ok, truncated,
//   bad header size, bad planes, bad bpp, compressed). Bytes after the result
//   and up to in_tlast are consumed without output.
//   The byte that completes a result passes the input register and the
//   capture logic; the result register then holds the result on out_tvalid.
//   Throughput: one byte per cycle while no result waits; the capture logic
//   handles each byte combinationally between the input and result registers.
//   Reset: rst_n clears the valid flags of both registers and all captured
//   fields; the parser then waits for byte 0 of a file, as after in_tlast.
//   Stall: while a result waits with out_tready low, a byte in the input
//   register is held unprocessed and in_tready is low until the result leaves.
// ----------------------------------------------------------------------------
module bmp_header_parser_top
  import bhp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,  // data_byte [7:0]
  input  logic                   in_tlast,  // frame_end
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // From bit 0: status[2:0], sig_word[18:3], file_bytes[50:19],
  // data_offset[82:51], header_size[114:83], img_width[146:115],
  // img_height[178:147], pixel_bits[194:179], image_size[226:195],
  // horizontal_ppm[258:227], vertical_ppm[290:259], color_count[322:291],
  // zero fill[327:323].
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic          stage_valid_r, stage_valid_nxt;
  logic [7:0]    stage_byte_r;
  logic          stage_last_r;
  logic          advance;
  logic          in_accept;
  logic          res_valid;
  bhp_result_t   res;
  bhp_result_t   out_res;
  bhp_byte_req_t req;

  // Input register: filled when empty or when its byte moves on.
  assign in_tready = !stage_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_tready) begin
      stage_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_byte_r <= in_tdata;
      stage_last_r <= in_tlast;
    end
  end

  // A byte is processed when the result register can take its outcome.
  assign req.fire      = stage_valid_r && advance;
  assign req.data_byte = stage_byte_r;
  assign req.frame_end = stage_last_r;

  bhp_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  bhp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result, last struct field (status) in the lowest bits.
  assign out_tdata = {{(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}}, out_res};

endmodule

FILE: test/tb_bmp_header_parser_top.sv
// ----------------------------------------------------------------------------
// tb_bmp_header_parser_top
// Self-checking testbench for the bitmap header parser. Whole and broken
// bitmap headers are streamed in one byte per request, with bursty input and
// a stalling result side. A scoreboard tracks the parser state on its own and
// checks each result request field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_bmp_header_parser_top
  import bhp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Ways to fill the header bytes that a file does not set explicitly.
  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RAND = 2;

  // Scoreboard: follows the header capture byte by byte and holds the
  // results that the parser still owes.
  class bmp_header_scoreboard;
    int          next_pos;
    bit          core_layout;
    bit          file_done;
    logic [31:0] signature;
    logic [31:0] file_bytes;
    logic [31:0] pixel_offset;
    logic [31:0] dib_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] planes;
    logic [31:0] bpp;
    logic [31:0] compression;
    logic [31:0] image_bytes;
    logic [31:0] hres;
    logic [31:0] vres;
    logic [31:0] colors;
    bhp_result_t expected_headers[$];
    int          errors;

    function new();
      errors = 0;
      restart_file();
    endfunction

    function void restart_file();
      next_pos = 0;
      core_layout = 1'b0;
      file_done = 1'b0;
      signature = '0;
      file_bytes = '0;
      pixel_offset = '0;
      dib_size = '0;
      width = '0;
      height = '0;
      planes = '0;
      bpp = '0;
      compression = '0;
      image_bytes = '0;
      hres = '0;
      vres = '0;
      colors = '0;
    endfunction

    // Places a byte into a little-endian field when the position falls in it.
    function logic [31:0] put_byte(logic [31:0] acc, int base, int len, int pos,
                                   logic [7:0] b);
      if (pos >= base && pos < base + len) acc[8*(pos-base) +: 8] = b;
      return acc;
    endfunction

    function bit bpp_supported(logic [31:0] v);
      return v == 1 || v == 4 || v == 8 || v == 16 || v == 24 || v == 32;
    endfunction

    function void post_result(bhp_status_t st);
      bhp_result_t r;
      r.status         = st;
      r.sig_word       = signature[15:0];
      r.file_bytes     = file_bytes;
      r.data_offset    = pixel_offset;
      r.header_size    = dib_size;
      r.img_width      = width;
      r.img_height     = height;
      r.pixel_bits     = bpp[15:0];
      r.image_size     = image_bytes;
      r.horizontal_ppm = hres;
      r.vertical_ppm   = vres;
      r.color_count    = colors;
      expected_headers.push_back(r);
      file_done = 1'b1;
    endfunction

    // Called for every accepted input request.
    function void take_byte(logic [7:0] b, logic last);
      int p;
      bhp_status_t st;
      if (!file_done) begin
        p = next_pos;
        signature    = put_byte(signature, 0, 2, p, b);
        file_bytes   = put_byte(file_bytes, 2, 4, p, b);
        pixel_offset = put_byte(pixel_offset, 10, 4, p, b);
        dib_size     = put_byte(dib_size, 14, 4, p, b);
        if (p == int'(POS_SIZE_LAST)) begin
          // The header size picks the layout or ends the file at once.
          if (dib_size == HS_CORE || dib_size == HS_CORE_OS2) begin
            core_layout = 1'b1;
          end else if (!(dib_size == HS_INFO || dib_size == HS_INFO_V2 ||
                         dib_size == HS_INFO_V3 || dib_size == HS_INFO_V4 ||
                         dib_size == HS_INFO_V5)) begin
            post_result(ST_BAD_SIZE);
          end
        end else if (p > int'(POS_SIZE_LAST)) begin
          if (core_layout) begin
            width  = put_byte(width, 18, 2, p, b);
            height = put_byte(height, 20, 2, p, b);
            planes = put_byte(planes, 22, 2, p, b);
            bpp    = put_byte(bpp, 24, 2, p, b);
            if (p == int'(POS_CORE_LAST)) post_result(ST_OK);
          end else begin
            width       = put_byte(width, 18, 4, p, b);
            height      = put_byte(height, 22, 4, p, b);
            planes      = put_byte(planes, 26, 2, p, b);
            bpp         = put_byte(bpp, 28, 2, p, b);
            compression = put_byte(compression, 30, 4, p, b);
            image_bytes = put_byte(image_bytes, 34, 4, p, b);
            hres        = put_byte(hres, 38, 4, p, b);
            vres        = put_byte(vres, 42, 4, p, b);
            colors      = put_byte(colors, 46, 4, p, b);
            if (p == int'(POS_INFO_LAST)) begin
              // Planes are checked first, then bpp, then compression.
              if (planes != 32'd1) st = ST_BAD_PLANES;
              else if (!bpp_supported(bpp)) st = ST_BAD_BPP;
              else if (compression != 32'd0) st = ST_COMPRESSED;
              else st = ST_OK;
              post_result(st);
            end
          end
        end
        if (!file_done) next_pos = p + 1;
        // A frame that ends before its result reports truncation.
        if (last && !file_done) post_result(ST_TRUNC);
      end
      if (last) restart_file();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Called for every accepted result request.
    task check_result(logic [OUT_TDATA_W-1:0] d);
      bhp_result_t got;
      bhp_result_t want;
      got = d[OUT_PAYLOAD_W-1:0];
      if (expected_headers.size() == 0) begin
        report_mismatch($sformatf("result with no expectation: %h", d));
      end else begin
        want = expected_headers.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("sig_word", 32'(got.sig_word), 32'(want.sig_word));
        check_field("file_bytes", got.file_bytes, want.file_bytes);
        check_field("data_offset", got.data_offset, want.data_offset);
        check_field("header_size", got.header_size, want.header_size);
        check_field("img_width", got.img_width, want.img_width);
        check_field("img_height", got.img_height, want.img_height);
        check_field("pixel_bits", 32'(got.pixel_bits), 32'(want.pixel_bits));
        check_field("image_size", got.image_size, want.image_size);
        check_field("horizontal_ppm", got.horizontal_ppm, want.horizontal_ppm);
        check_field("vertical_ppm", got.vertical_ppm, want.vertical_ppm);
        check_field("color_count", got.color_count, want.color_count);
        check_field("zero fill", 32'(d[OUT_TDATA_W-1:OUT_PAYLOAD_W]), 32'd0);
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bmp_header_scoreboard sb = new();

  // Header image of the file being sent.
  logic [7:0] file_img [64];
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  bit         hold_request = 1'b0;

  bmp_header_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Writes a little-endian value into the header image.
  function automatic void set_le(int pos, int len, logic [31:0] value);
    for (int i = 0; i < len; i++) file_img[pos+i] = value[8*i +: 8];
  endfunction

  // Offers one byte request and waits until it is taken. The sender works
  // in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b, last);
    bytes_sent++;
  endtask

  // Builds a file image and sends its first len bytes, the last with tlast.
  // A raw file keeps its random bytes; otherwise the layout fields are set.
  task automatic run_file(input logic [31:0] hs, input logic [15:0] pl,
                          input logic [15:0] bp, input logic [31:0] cp,
                          input int fill, input int len, input bit raw);
    for (int i = 0; i < 64; i++) begin
      case (fill)
        FILL_ZERO: file_img[i] = 8'h00;
        FILL_ONES: file_img[i] = 8'hFF;
        default:   file_img[i] = 8'($urandom);
      endcase
    end
    if (!raw) begin
      if ($urandom_range(0, 1) == 1) set_le(0, 2, 32'h4D42);
      set_le(14, 4, hs);
      if (hs == HS_CORE || hs == HS_CORE_OS2) begin
        set_le(22, 2, 32'(pl));
        set_le(24, 2, 32'(bp));
      end else begin
        set_le(26, 2, 32'(pl));
        set_le(28, 2, 32'(bp));
        set_le(30, 4, cp);
      end
    end
    for (int i = 0; i < len; i++) send_byte(file_img[i], i == len - 1);
    files_sent++;
  endtask

  // One random file: headers of valid or random size and random content,
  // mostly complete, some truncated and some plain noise.
  task automatic random_file();
    logic [31:0] hs;
    logic [15:0] pl;
    logic [15:0] bp;
    logic [31:0] cp;
    int          fill;
    int          last_pos;
    int          len;
    int          shape;
    int          pick;
    pick = $urandom_range(0, 15);
    if (pick < 12) begin
      case ($urandom_range(0, 6))
        0: hs = HS_INFO;
        1: hs = HS_INFO_V2;
        2: hs = HS_INFO_V3;
        3: hs = HS_INFO_V4;
        4: hs = HS_INFO_V5;
        5: hs = HS_CORE;
        default: hs = HS_CORE_OS2;
      endcase
    end else if (pick < 15) begin
      hs = $urandom_range(0, 130);
    end else begin
      hs = $urandom;
    end
    pl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd1;
    case ($urandom_range(0, 9))
      0: bp = 16'd1;
      1: bp = 16'd4;
      2: bp = 16'd8;
      3: bp = 16'd16;
      4: bp = 16'd24;
      5: bp = 16'd32;
      6: bp = 16'($urandom);
      7: bp = 16'($urandom_range(0, 40));
      default: bp = 16'd24;
    endcase
    cp = ($urandom_range(0, 5) == 0) ? $urandom : 32'd0;
    case ($urandom_range(0, 7))
      0: fill = FILL_ZERO;
      1: fill = FILL_ONES;
      default: fill = FILL_RAND;
    endcase
    if (hs == HS_CORE || hs == HS_CORE_OS2) last_pos = int'(POS_CORE_LAST);
    else if (hs == HS_INFO || hs == HS_INFO_V2 || hs == HS_INFO_V3 ||
             hs == HS_INFO_V4 || hs == HS_INFO_V5) last_pos = int'(POS_INFO_LAST);
    else last_pos = int'(POS_SIZE_LAST);
    shape = $urandom_range(0, 9);
    if (shape < 7) begin
      len = last_pos + 1 + $urandom_range(0, 5);
      run_file(hs, pl, bp, cp, fill, len, 1'b0);
    end else if (shape < 9) begin
      len = $urandom_range(1, last_pos);
      run_file(hs, pl, bp, cp, fill, len, 1'b0);
    end else begin
      run_file(hs, pl, bp, cp, FILL_RAND, $urandom_range(1, 60), 1'b1);
    end
  endtask

  // Result side: stalls on a pattern of its own, in segments of random mode,
  // and holds off for a long stretch when the sender asks for it.
  initial begin : ready_pattern
    int mode;
    int seg;
    int hold;
    mode = 0;
    seg = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 400;
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(5, 60);
      end
      seg--;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (seg % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Main sequence: reset, directed files, random files, drain.
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every layout and status, and the frame-end corners.
    run_file(HS_INFO, 16'd1, 16'd24, 32'd0, FILL_RAND, 56, 1'b0);
    run_file(HS_INFO_V5, 16'd1, 16'd32, 32'd0, FILL_ONES, 54, 1'b0);
    run_file(HS_INFO_V2, 16'd1, 16'd1, 32'd0, FILL_ZERO, 55, 1'b0);
    run_file(HS_INFO_V3, 16'd1, 16'd4, 32'd0, FILL_RAND, 54, 1'b0);
    run_file(HS_INFO_V4, 16'd1, 16'd16, 32'd0, FILL_RAND, 57, 1'b0);
    run_file(HS_CORE, 16'd1, 16'd8, 32'd0, FILL_RAND, 26, 1'b0);
    run_file(HS_CORE_OS2, 16'hFFFF, 16'hFFFF, 32'd0, FILL_ONES, 29, 1'b0);
    run_file(32'd0, 16'd1, 16'd8, 32'd0, FILL_ZERO, 18, 1'b0);
    run_file(32'hFFFF_FFFF, 16'd1, 16'd8, 32'd0, FILL_ONES, 22, 1'b0);
    run_file(HS_INFO, 16'd0, 16'd24, 32'd0, FILL_RAND, 54, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd2, 32'd0, FILL_RAND, 54, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd24, 32'd1, FILL_RAND, 54, 1'b0);
    run_file(HS_INFO, 16'd2, 16'd3, 32'd5, FILL_RAND, 55, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd7, 32'd3, FILL_RAND, 54, 1'b0);
    // Truncation: on the first byte, on the size byte, mid-header, and one
    // byte short of the end.
    run_file(HS_INFO, 16'd1, 16'd8, 32'd0, FILL_RAND, 1, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd8, 32'd0, FILL_RAND, 18, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd8, 32'd0, FILL_RAND, 30, 1'b0);
    run_file(HS_CORE, 16'd1, 16'd8, 32'd0, FILL_RAND, 21, 1'b0);
    run_file(HS_INFO, 16'd1, 16'd8, 32'd0, FILL_RAND, 53, 1'b0);

    // Random part, with one long receiver hold-off early on while short
    // files keep arriving back to back.
    while (bytes_sent < 1550 || files_sent < 40) begin
      random_file();
      if (files_sent == 25) begin
        hold_request = 1'b1;
        burst_left = 1000;
        repeat (30) run_file(HS_INFO, 16'd1, 16'd8, 32'd0, FILL_RAND,
                             $urandom_range(1, 3), 1'b0);
        burst_left = 0;
      end
    end

    // Drain: wait for every expected result, then idle before reporting.
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (sb.expected_headers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bhp_pkg.sv
hw/rtl/bhp_capture.sv
hw/rtl/bhp_out_stage.sv
hw/rtl/bmp_header_parser_top.sv
test/tb_bmp_header_parser_top.sv
